// File: hw/rtl/tepf_pkg.sv
// Package for the terminal escape and private-use filter.
// Holds byte codes, string kinds, register indexes and the command type
// shared by the front, queue, back and top level. No dependencies.
`timescale 1ns / 1ps

package tepf_pkg;

    // Byte codes
    localparam logic [7:0] BYTE_BEL    = 8'h07;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_OSC    = 8'h5D;  // ']'
    localparam logic [7:0] BYTE_DCS    = 8'h50;  // 'P'
    localparam logic [7:0] BYTE_APC    = 8'h5F;  // '_'
    localparam logic [7:0] BYTE_PM     = 8'h5E;  // '^'

    // String kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_OSC  = 3'd1;
    localparam logic [2:0] KIND_DCS  = 3'd2;
    localparam logic [2:0] KIND_APC  = 3'd3;
    localparam logic [2:0] KIND_PM   = 3'd4;

    // UTF-8 sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Register map
    localparam int          CP_W     = 21;
    localparam int          ADDR_W   = 4;
    localparam logic [1:0]  REG_LOW  = 2'd0;
    localparam logic [1:0]  REG_HIGH = 2'd1;
    localparam logic [1:0]  REG_SUB  = 2'd2;

    localparam logic [CP_W-1:0] RST_LOW  = 21'h00E000;
    localparam logic [CP_W-1:0] RST_HIGH = 21'h00F8FF;
    localparam logic [7:0]      RST_SUB  = 8'h20;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 4;

    // One command: up to four bytes to emit, and the index of the last one
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_cmd;

    // Map the byte after ESC to the string kind it opens
    function automatic logic [2:0] kind_of(input logic [7:0] b);
        logic [2:0] k;
        unique case (b)
            BYTE_OSC: k = KIND_OSC;
            BYTE_DCS: k = KIND_DCS;
            BYTE_APC: k = KIND_APC;
            BYTE_PM:  k = KIND_PM;
            default:  k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/terminal_escape_and_pua_filter_unit.sv
// Top level of the terminal escape and private-use filter.
// Instantiates tepf_front, tepf_queue and tepf_back; holds the APB
// registers. Uses tepf_pkg.
//
// Usage:
//   Input channel: drive i_in_byte and raise push; a byte is transferred
//   at a clock edge with push high and full low. Output channel: while
//   empty is low, o_out_byte/o_run_last show the oldest result; raise pop
//   to transfer it. o_run_last marks the final byte caused by one input.
//   An input byte that causes results passes as a command through the queue
//   into the back end's output register, where its first result shows. Input
//   bytes are taken one per cycle while the command queue (QDepth entries)
//   has room; results leave one byte per cycle while pop is high and empty
//   is low. An input causing four bytes holds the back end until all four
//   have left, so the output rate of the back end sets the sustained throughput.
//   When pop stays low the queue fills and full rises; no byte is lost.
//   Synchronous reset clears the escape, string and UTF-8 state, empties
//   the queue and sets replace_low 0xE000, replace_high 0xF8FF and
//   substitute_byte 0x20. Registers sit at 0x0, 0x4 and 0x8.
`timescale 1ns / 1ps

module terminal_escape_and_pua_filter_unit #(
    parameter int QDepth = tepf_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_in_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_out_byte,
    output logic                        o_run_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tepf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [tepf_pkg::CP_W-1:0] r_low, r_high;
    logic [7:0]                r_sub;
    logic [1:0]                v_reg;
    logic                      v_wr;

    logic           v_in_xfer;
    logic           v_cmd_valid;
    tepf_pkg::t_cmd v_cmd;
    logic           v_q_full, v_q_empty, v_q_pop;
    tepf_pkg::t_cmd v_q_data;

    assign pready = 1'b1;
    assign v_reg  = paddr[3:2];
    assign v_wr   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= tepf_pkg::RST_LOW;
            r_high <= tepf_pkg::RST_HIGH;
            r_sub  <= tepf_pkg::RST_SUB;
        end else if (v_wr) begin
            unique case (v_reg)
                tepf_pkg::REG_LOW:  r_low  <= pwdata[tepf_pkg::CP_W-1:0];
                tepf_pkg::REG_HIGH: r_high <= pwdata[tepf_pkg::CP_W-1:0];
                tepf_pkg::REG_SUB:  r_sub  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (v_reg)
            tepf_pkg::REG_LOW:  prdata = {11'd0, r_low};
            tepf_pkg::REG_HIGH: prdata = {11'd0, r_high};
            tepf_pkg::REG_SUB:  prdata = {24'd0, r_sub};
            default:            prdata = 32'd0;
        endcase
    end

    assign full      = v_q_full;
    assign v_in_xfer = push && !v_q_full;

    tepf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v_in_xfer),
        .i_byte      (i_in_byte),
        .i_low       (r_low),
        .i_high      (r_high),
        .i_sub       (r_sub),
        .o_cmd_valid (v_cmd_valid),
        .o_cmd       (v_cmd)
    );

    tepf_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (v_cmd_valid),
        .i_data  (v_cmd),
        .i_pop   (v_q_pop),
        .o_full  (v_q_full),
        .o_empty (v_q_empty),
        .o_data  (v_q_data)
    );

    tepf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (v_q_empty),
        .i_q_data   (v_q_data),
        .o_q_pop    (v_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

// File: hw/rtl/tepf_front.sv
// Front end of the filter: escape/string tracking and UTF-8 collection.
// Turns each accepted byte into zero or one emit command. Uses tepf_pkg.
`timescale 1ns / 1ps

module tepf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_byte,
    input  logic [tepf_pkg::CP_W-1:0] i_low,
    input  logic [tepf_pkg::CP_W-1:0] i_high,
    input  logic [7:0]                i_sub,
    output logic                      o_cmd_valid,
    output tepf_pkg::t_cmd            o_cmd
);

    logic            r_esc, n_esc;
    logic [2:0]      r_kind, n_kind;
    logic            r_sesc, n_sesc;
    logic [2:0]      r_exp, n_exp;
    logic [2:0]      r_col, n_col;
    logic [3:0][7:0] r_ub, n_ub;

    logic [3:0][7:0]          v_bytes;
    logic [tepf_pkg::CP_W-1:0] v_cp;
    logic [2:0]               v_kind;

    // Sequence bytes with the current byte merged in
    always_comb begin
        v_bytes = r_ub;
        v_bytes[r_col[1:0]] = i_byte;
    end

    // Decode the code point of a completed sequence
    always_comb begin
        unique case (r_exp)
            tepf_pkg::LEN_2: v_cp = {10'd0, v_bytes[0][4:0], v_bytes[1][5:0]};
            tepf_pkg::LEN_3: v_cp = {5'd0, v_bytes[0][3:0], v_bytes[1][5:0],
                                     v_bytes[2][5:0]};
            default:         v_cp = {v_bytes[0][2:0], v_bytes[1][5:0],
                                     v_bytes[2][5:0], v_bytes[3][5:0]};
        endcase
    end

    assign v_kind = tepf_pkg::kind_of(i_byte);

    // Classify the byte and advance the state
    always_comb begin
        n_esc       = r_esc;
        n_kind      = r_kind;
        n_sesc      = r_sesc;
        n_exp       = r_exp;
        n_col       = r_col;
        n_ub        = r_ub;
        o_cmd_valid = 1'b0;
        o_cmd.bytes    = v_bytes;
        o_cmd.last_idx = 2'd0;
        if (i_valid) begin
            if (r_exp != tepf_pkg::LEN_NONE) begin
                n_ub  = v_bytes;
                n_col = r_col + 3'd1;
                if ((r_col + 3'd1) >= r_exp) begin
                    n_exp       = tepf_pkg::LEN_NONE;
                    n_col       = 3'd0;
                    o_cmd_valid = 1'b1;
                    if (v_cp >= i_low && v_cp <= i_high) begin
                        o_cmd.bytes[0] = i_sub;
                        o_cmd.last_idx = 2'd0;
                    end else begin
                        o_cmd.last_idx = r_exp[1:0] - 2'd1;
                    end
                end
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (v_kind != tepf_pkg::KIND_NONE) begin
                    n_kind = v_kind;
                end else begin
                    o_cmd_valid    = 1'b1;
                    o_cmd.bytes[0] = tepf_pkg::BYTE_ESC;
                    o_cmd.bytes[1] = i_byte;
                    o_cmd.last_idx = 2'd1;
                end
            end else if (r_kind != tepf_pkg::KIND_NONE) begin
                // Swallow string bytes; close on BEL or ESC backslash
                n_sesc = 1'b0;
                if (r_sesc && i_byte == tepf_pkg::BYTE_BSLASH) begin
                    n_kind = tepf_pkg::KIND_NONE;
                end else if (i_byte == tepf_pkg::BYTE_BEL) begin
                    n_kind = tepf_pkg::KIND_NONE;
                end else if (i_byte == tepf_pkg::BYTE_ESC) begin
                    n_sesc = 1'b1;
                end
            end else if (i_byte == tepf_pkg::BYTE_ESC) begin
                n_esc = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_exp    = tepf_pkg::LEN_2;
                n_col    = 3'd1;
                n_ub[0]  = i_byte;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_exp    = tepf_pkg::LEN_3;
                n_col    = 3'd1;
                n_ub[0]  = i_byte;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_exp    = tepf_pkg::LEN_4;
                n_col    = 3'd1;
                n_ub[0]  = i_byte;
            end else begin
                o_cmd_valid    = 1'b1;
                o_cmd.bytes[0] = i_byte;
                o_cmd.last_idx = 2'd0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_kind <= tepf_pkg::KIND_NONE;
            r_sesc <= 1'b0;
            r_exp  <= tepf_pkg::LEN_NONE;
            r_col  <= 3'd0;
        end else begin
            r_esc  <= n_esc;
            r_kind <= n_kind;
            r_sesc <= n_sesc;
            r_exp  <= n_exp;
            r_col  <= n_col;
        end
    end

    // Sequence bytes need no reset: always written before read
    always_ff @(posedge i_clk) begin
        r_ub <= n_ub;
    end

endmodule

// File: hw/rtl/tepf_queue.sv
// Short command queue between front and back of the filter.
// Circular buffer of tepf_pkg::t_cmd entries. Uses tepf_pkg.
`timescale 1ns / 1ps

module tepf_queue #(
    parameter int Depth = tepf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tepf_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tepf_pkg::t_cmd o_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    tepf_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            v_push, v_pop;

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign v_push  = i_push && !o_full;
    assign v_pop   = i_pop && !o_empty;

    // Store an entry on each push
    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (v_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + PtrW'(1);
            end
            if (v_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + PtrW'(1);
            end
            if (v_push && !v_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (v_pop && !v_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/tepf_back.sv
// Back end of the filter: plays out each command one byte per transfer.
// Output register holds the current command. Uses tepf_pkg.
`timescale 1ns / 1ps

module tepf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  tepf_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);

    logic           r_valid;
    tepf_pkg::t_cmd r_cmd;
    logic [1:0]     r_idx;
    logic           v_done;

    assign o_empty    = !r_valid;
    assign o_out_byte = r_cmd.bytes[r_idx];
    assign o_run_last = (r_idx == r_cmd.last_idx);
    assign v_done     = r_valid && i_pop && o_run_last;
    assign o_q_pop    = !i_q_empty && (!r_valid || v_done);

    // Load the next command or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (v_done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_pop) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    // Command payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
    end

endmodule

// File: tb/sv/terminal_escape_and_pua_filter_unit_tb.sv
// Testbench for terminal_escape_and_pua_filter_unit: directed and random byte
// streams through the push/pop queue ports, APB register writes between phases.
// Depends on tepf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module terminal_escape_and_pua_filter_unit_tb;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 72;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_filtered_byte;

    // Predict the filtered stream and match it against the block's output
    class t_filter_scoreboard;
        logic [tepf_pkg::CP_W-1:0] cp_lo;
        logic [tepf_pkg::CP_W-1:0] cp_hi;
        logic [7:0]                sub_byte;
        bit                        esc_armed;
        logic [2:0]                str_kind;
        bit                        str_esc;
        logic [7:0]                seq_buf [4];
        logic [2:0]                seq_len;
        logic [2:0]                seq_cnt;
        t_filtered_byte            pending_bytes [$];
        int                        errors;

        function new();
            cp_lo     = tepf_pkg::RST_LOW;
            cp_hi     = tepf_pkg::RST_HIGH;
            sub_byte  = tepf_pkg::RST_SUB;
            esc_armed = 1'b0;
            str_kind  = tepf_pkg::KIND_NONE;
            str_esc   = 1'b0;
            seq_len   = tepf_pkg::LEN_NONE;
            seq_cnt   = 3'd0;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                tepf_pkg::REG_LOW:  cp_lo = value[tepf_pkg::CP_W-1:0];
                tepf_pkg::REG_HIGH: cp_hi = value[tepf_pkg::CP_W-1:0];
                tepf_pkg::REG_SUB:  sub_byte = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [2:0] string_kind_for(logic [7:0] b);
            case (b)
                tepf_pkg::BYTE_OSC: return tepf_pkg::KIND_OSC;
                tepf_pkg::BYTE_DCS: return tepf_pkg::KIND_DCS;
                tepf_pkg::BYTE_APC: return tepf_pkg::KIND_APC;
                tepf_pkg::BYTE_PM:  return tepf_pkg::KIND_PM;
                default:            return tepf_pkg::KIND_NONE;
            endcase
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction

        // Advance the filter state by one accepted byte, queue what it emits
        function void take_input_byte(logic [7:0] b);
            logic [7:0]                run [$];
            logic [tepf_pkg::CP_W-1:0] cp;
            logic [2:0]                k;
            t_filtered_byte            item;
            int                        i;
            if (seq_len != tepf_pkg::LEN_NONE) begin
                // Continuation bytes are taken as they come, no check
                seq_buf[seq_cnt[1:0]] = b;
                seq_cnt = seq_cnt + 3'd1;
                if (seq_cnt == seq_len) begin
                    case (seq_len)
                        tepf_pkg::LEN_2: cp = {10'd0, seq_buf[0][4:0], seq_buf[1][5:0]};
                        tepf_pkg::LEN_3: cp = {5'd0, seq_buf[0][3:0], seq_buf[1][5:0],
                                               seq_buf[2][5:0]};
                        default:         cp = {seq_buf[0][2:0], seq_buf[1][5:0],
                                               seq_buf[2][5:0], seq_buf[3][5:0]};
                    endcase
                    if (cp >= cp_lo && cp <= cp_hi) begin
                        run.insert(run.size(), sub_byte);
                    end else begin
                        for (i = 0; i < seq_len; i++) run.insert(run.size(), seq_buf[i]);
                    end
                    seq_len = tepf_pkg::LEN_NONE;
                    seq_cnt = 3'd0;
                end
            end else if (esc_armed) begin
                esc_armed = 1'b0;
                k = string_kind_for(b);
                if (k != tepf_pkg::KIND_NONE) begin
                    str_kind = k;
                end else begin
                    run.insert(run.size(), tepf_pkg::BYTE_ESC);
                    run.insert(run.size(), b);
                end
            end else if (str_kind != tepf_pkg::KIND_NONE) begin
                // Swallow string bytes; close on BEL or ESC backslash
                if (str_esc && b == tepf_pkg::BYTE_BSLASH) begin
                    str_esc  = 1'b0;
                    str_kind = tepf_pkg::KIND_NONE;
                end else begin
                    str_esc = 1'b0;
                    if (b == tepf_pkg::BYTE_BEL) str_kind = tepf_pkg::KIND_NONE;
                    else if (b == tepf_pkg::BYTE_ESC) str_esc = 1'b1;
                end
            end else if (b == tepf_pkg::BYTE_ESC) begin
                esc_armed = 1'b1;
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 ||
                         b[7:3] == 5'b11110) begin
                seq_len    = (b[7:5] == 3'b110) ? tepf_pkg::LEN_2 :
                             (b[7:4] == 4'b1110) ? tepf_pkg::LEN_3 : tepf_pkg::LEN_4;
                seq_buf[0] = b;
                seq_cnt    = 3'd1;
            end else begin
                run.insert(run.size(), b);
            end
            foreach (run[j]) begin
                item.data = run[j];
                item.last = (j == run.size() - 1);
                pending_bytes.insert(pending_bytes.size(), item);
            end
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_filtered_byte(logic [7:0] data, logic last);
            t_filtered_byte want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected result %02h (run_last %0b)", $time, data, last);
                errors++;
                return;
            end
            want = pending_bytes[0];
            pending_bytes.delete(0);
            if (data !== want.data) begin
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: run_last mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function void report_leftovers();
            if (pending_bytes.size() != 0) begin
                $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        push      = 1'b0;
    logic                        full;
    logic [7:0]                  i_in_byte = 8'h00;
    logic                        empty;
    logic                        pop       = 1'b0;
    logic [7:0]                  o_out_byte;
    logic                        o_run_last;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [tepf_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = 32'h0;
    logic [31:0]                 prdata;
    logic                        pready;

    t_filter_scoreboard sb;
    bit                 calm        = 1'b0;
    bit                 hold_req    = 1'b0;
    bit                 hold_active = 1'b0;
    int                 idle_cycles = 0;
    int                 bytes_sent  = 0;

    // Register settings per phase; phase 0 runs on the reset values
    logic [31:0] low_setting  [NUM_PHASES] = '{32'h0, 32'h0, 32'h10FFFF, 32'hE9,
                                               32'h80, 32'h0E000};
    logic [31:0] high_setting [NUM_PHASES] = '{32'h0, 32'h10FFFF, 32'h0, 32'hE9,
                                               32'h7FF, 32'h0F8FF};
    logic [31:0] sub_setting  [NUM_PHASES] = '{32'h0, 32'hFF, 32'h00, 32'h3F,
                                               32'hA5, 32'h20};

    // Opening run: plain and stray bytes, every string kind and terminator,
    // dropped escape in a string, ESC ESC, a private-use code point, and a
    // 4-byte sequence carrying ESC and BEL as continuation bytes
    logic [7:0] opening_run [29] = '{
        8'h41, 8'hFF,
        tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_OSC, tepf_pkg::BYTE_BEL,
        tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_DCS, 8'h78, tepf_pkg::BYTE_ESC,
        tepf_pkg::BYTE_BSLASH,
        tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_APC, tepf_pkg::BYTE_ESC, 8'h71,
        tepf_pkg::BYTE_BEL,
        tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_PM, tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_ESC,
        tepf_pkg::BYTE_BSLASH,
        tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_ESC,
        8'hEE, 8'h80, 8'h80,
        8'hF7, tepf_pkg::BYTE_ESC, tepf_pkg::BYTE_BEL, 8'hBF
    };

    terminal_escape_and_pua_filter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 i_clk = ~i_clk;

    // Observe both transfers on every edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.take_input_byte(i_in_byte);
            if (pop && !empty) sb.check_filtered_byte(o_out_byte, o_run_last);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: runs of pop, random stall bursts, one long hold on request
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Offer one byte, with an occasional gap first; return on its transfer
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop push, wait for every expected byte, then let the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (sb.pending_count() == 0) break;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tepf_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Send one random segment; count the bytes it sends
    task automatic send_segment(output int counted);
        int                        pick;
        int                        len;
        int                        k;
        int                        body;
        int                        start;
        logic [tepf_pkg::CP_W-1:0] cp;
        logic [31:0]               span;
        logic [7:0]                b;
        start = bytes_sent;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // Plain ASCII
            b = 8'($urandom_range(0, 127));
            if (b == tepf_pkg::BYTE_ESC) b = 8'h20;
            send_byte(b);
        end else if (pick < 60) begin
            // UTF-8 sequence, often aimed at the replacement range
            if (sb.cp_lo <= sb.cp_hi && $urandom_range(0, 2) == 0) begin
                span = 32'(sb.cp_hi) - 32'(sb.cp_lo) + 32'd1;
                cp   = tepf_pkg::CP_W'(32'(sb.cp_lo) + ($urandom % span));
                len  = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
                if (len < 4 && $urandom_range(0, 4) == 0) len++;
            end else begin
                len = $urandom_range(2, 4);
                cp  = tepf_pkg::CP_W'($urandom);
            end
            case (len)
                2:       b = {3'b110, cp[10:6]};
                3:       b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
            send_byte(b);
            for (k = 1; k < len; k++) begin
                b = 8'h80 | 8'((cp >> (6 * (len - 1 - k))) & 21'h3F);
                if ($urandom_range(0, 9) == 0) b = 8'($urandom);
                send_byte(b);
            end
        end else if (pick < 75) begin
            // Escape string with random body and either terminator
            send_byte(tepf_pkg::BYTE_ESC);
            case ($urandom_range(0, 3))
                0:       b = tepf_pkg::BYTE_OSC;
                1:       b = tepf_pkg::BYTE_DCS;
                2:       b = tepf_pkg::BYTE_APC;
                default: b = tepf_pkg::BYTE_PM;
            endcase
            send_byte(b);
            body = $urandom_range(0, 6);
            for (k = 0; k < body; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_byte(tepf_pkg::BYTE_ESC);
                    b = 8'($urandom_range(8'h20, 8'h7E));
                    if (b == tepf_pkg::BYTE_BSLASH) b = 8'h41;
                    send_byte(b);
                end else begin
                    send_byte(8'($urandom_range(8'h20, 8'hFF)));
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                send_byte(tepf_pkg::BYTE_BEL);
            end else begin
                send_byte(tepf_pkg::BYTE_ESC);
                send_byte(tepf_pkg::BYTE_BSLASH);
            end
        end else if (pick < 85) begin
            // ESC followed by a byte that opens no string
            b = 8'($urandom_range(0, 255));
            if (b == tepf_pkg::BYTE_OSC || b == tepf_pkg::BYTE_DCS ||
                b == tepf_pkg::BYTE_APC || b == tepf_pkg::BYTE_PM) b = 8'h41;
            send_byte(tepf_pkg::BYTE_ESC);
            send_byte(b);
        end else if (pick < 93) begin
            // Stray bytes outside a sequence
            if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h80, 8'hBF));
            else b = 8'($urandom_range(8'hF8, 8'hFF));
            send_byte(b);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
        counted = bytes_sent - start;
    endtask

    initial begin
        int got;
        int phase;
        int done;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (opening_run[i]) send_byte(opening_run[i]);
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_idle();
                write_reg(tepf_pkg::REG_LOW, low_setting[phase]);
                write_reg(tepf_pkg::REG_HIGH, high_setting[phase]);
                write_reg(tepf_pkg::REG_SUB, sub_setting[phase]);
            end
            if (phase == NUM_PHASES - 1) calm = 1'b1;
            done = 0;
            // Hold the receiver off while bytes keep coming, so full rises
            if (phase == 1) begin
                hold_req = 1'b1;
                wait (hold_active);
                repeat (PRESSURE_ITEMS) send_byte(8'($urandom_range(8'h20, 8'h7E)));
                done = PRESSURE_ITEMS;
            end
            while (done < PHASE_ITEMS) begin
                send_segment(got);
                done += got;
            end
        end
        wait_idle();
        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tepf_pkg.sv
hw/rtl/tepf_front.sv
hw/rtl/tepf_queue.sv
hw/rtl/tepf_back.sv
hw/rtl/terminal_escape_and_pua_filter_unit.sv
tb/sv/terminal_escape_and_pua_filter_unit_tb.sv
